### rtl/rioe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rioe_pkg
// Shared types and constants of the IR to x86-64 register-op encoder.
// ----------------------------------------------------------------------------
package rioe_pkg;

	// Register map sizing.
	localparam int MAP_DEPTH = 64;
	localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int MAP_CW    = $clog2(MAP_DEPTH + 1);
	localparam int PHYS_W    = 4;

	// Job queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Longest byte sequence of one item.
	localparam int MAX_BYTES = 7;
	localparam int LEN_W     = 3;

	// Commands.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_INSN  = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	// IR opcodes.
	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_LOAD = 3'd2;
	localparam logic [2:0] OP_RET  = 3'd3;

	// Operand kinds.
	localparam logic [1:0] KIND_REG = 2'd0;
	localparam logic [1:0] KIND_IMM = 2'd1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_UNSUP = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Machine code bytes.
	localparam logic [7:0] BYTE_PUSH_RBP = 8'h55;
	localparam logic [7:0] BYTE_REX_W    = 8'h48;
	localparam logic [7:0] BYTE_MOV_RM   = 8'h89;
	localparam logic [7:0] BYTE_RSP_RBP  = 8'hE5;
	localparam logic [7:0] BYTE_POP_RBP  = 8'h5D;
	localparam logic [7:0] BYTE_RET      = 8'hC3;
	localparam logic [7:0] BYTE_ADD      = 8'h01;
	localparam logic [7:0] BYTE_SUB      = 8'h29;
	localparam logic [7:0] BYTE_MOV_IMM  = 8'hC7;

	typedef enum logic [2:0] {
		JOB_PRO  = 3'd0,
		JOB_EPI  = 3'd1,
		JOB_RET  = 3'd2,
		JOB_ALU  = 3'd3,
		JOB_LOAD = 3'd4,
		JOB_ERR  = 3'd5
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        is_sub;
		logic [1:0]  status;
		logic [31:0] dest_vreg;
		logic [31:0] src1_vreg;
		logic [31:0] src2_vreg;
		logic [31:0] imm_value;
	} job_t;

endpackage

### rtl/ir_to_x86_register_op_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_to_x86_register_op_encoder_unit
// Turns IR items into x86-64 machine code, one byte per output transfer.
// ----------------------------------------------------------------------------
// Each input transfer on the s_ group carries one IR item: a start-function,
// translate-instruction or end-function command. Its bytes leave on the m_
// group one per transfer, the final byte of an item marked by m_tlast and
// every byte tagged with a status in m_tuser. A rejected item gives a single
// zero byte with its error status. An end-function that directly follows a
// return byte produces no transfer at all.
// The front stage checks each item and hands it to a two-entry job queue, so
// new items keep being accepted while the back end still works or while the
// receiver stalls; once the queue and front stage are full, s_tready drops.
// An item passes through the front stage register and the queue before the
// back end takes it. The back end takes one job at a time. A prologue,
// epilogue, return or error job is taken and its bytes are then emitted.
// ADD, SUB and load-immediate first search the register map one entry per
// cycle through its memory read port, then map each register, adding any
// not found (or giving ST_FULL when the map is full), build the bytes and
// emit them. Output is held in a register until m_tready takes it; the back
// end waits for the slot to free.
// Reset clears the map count, the last-byte record and all handshake state.
// The map memory itself is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
module ir_to_x86_register_op_encoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// opcode, source count, dest_kind, src1_kind, src2_kind, dest_vreg,
	// src1_vreg, src2_vreg, imm_value, then three unused bits
	input  logic [143:0]  s_tdata,
	// cmd
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// code_byte
	output logic [7:0]    m_tdata,
	output logic          m_tlast,
	// status
	output logic [1:0]    m_tuser
);
	import rioe_pkg::*;

	logic q_push_valid;
	logic q_push_ready;
	job_t q_push_job;
	logic q_pop_valid;
	logic q_pop_ready;
	job_t q_pop_job;

	rioe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.cmd           (s_tuser),
		.opcode        (s_tdata[2:0]),
		.src_count     (s_tdata[6:3]),
		.dest_kind     (s_tdata[8:7]),
		.src1_kind     (s_tdata[10:9]),
		.src2_kind     (s_tdata[12:11]),
		.dest_vreg     (s_tdata[44:13]),
		.src1_vreg     (s_tdata[76:45]),
		.src2_vreg     (s_tdata[108:77]),
		.imm_value     (s_tdata[140:109]),
		.push_valid    (q_push_valid),
		.push_ready    (q_push_ready),
		.push_job      (q_push_job)
	);

	rioe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_job   (q_push_job),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_job    (q_pop_job)
	);

	rioe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_pop_valid),
		.job_ready     (q_pop_ready),
		.job           (q_pop_job),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_code_byte (m_tdata),
		.out_last      (m_tlast),
		.out_status    (m_tuser)
	);

	// An error result is always a lone zero byte closing its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata == 8'h00))
		else $error("error result is not a single zero byte");

	// A checked job waiting on a full queue is neither dropped nor altered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push_valid && !q_push_ready) |=> (q_push_valid && $stable(q_push_job)))
		else $error("front stage lost or changed a job while the queue was full");

endmodule

### rtl/rioe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rioe_front
// Accepts IR items, checks them and turns each into one job for the back end.
// ----------------------------------------------------------------------------
module rioe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [2:0]          opcode,
	input  logic [3:0]          src_count,
	input  logic [1:0]          dest_kind,
	input  logic [1:0]          src1_kind,
	input  logic [1:0]          src2_kind,
	input  logic [31:0]         dest_vreg,
	input  logic [31:0]         src1_vreg,
	input  logic [31:0]         src2_vreg,
	input  logic [31:0]         imm_value,
	output logic                push_valid,
	input  logic                push_ready,
	output rioe_pkg::job_t      push_job
);
	import rioe_pkg::*;

	logic valid_s1;
	job_t job_s1;
	job_t job_new;

	// Checks follow the fixed order: operand count, then operand kinds.
	always_comb begin
		job_new           = '0;
		job_new.dest_vreg = dest_vreg;
		job_new.src1_vreg = src1_vreg;
		job_new.src2_vreg = src2_vreg;
		job_new.imm_value = imm_value;
		job_new.is_sub    = (opcode == OP_SUB);
		job_new.status    = ST_OK;
		job_new.kind      = JOB_ERR;
		case (cmd)
			CMD_START: job_new.kind = JOB_PRO;
			CMD_END:   job_new.kind = JOB_EPI;
			CMD_INSN: begin
				case (opcode)
					OP_ADD, OP_SUB: begin
						if (src_count != 4'd2) begin
							job_new.status = ST_COUNT;
						end else if (dest_kind != KIND_REG || src1_kind != KIND_REG ||
								src2_kind != KIND_REG) begin
							job_new.status = ST_UNSUP;
						end else begin
							job_new.kind = JOB_ALU;
						end
					end
					OP_LOAD: begin
						if (src_count != 4'd1) begin
							job_new.status = ST_COUNT;
						end else if (dest_kind != KIND_REG || src1_kind != KIND_IMM) begin
							job_new.status = ST_UNSUP;
						end else begin
							job_new.kind = JOB_LOAD;
						end
					end
					OP_RET:  job_new.kind = JOB_RET;
					default: job_new.status = ST_UNSUP;
				endcase
			end
			default: job_new.status = ST_UNSUP;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1 <= job_new;
		end
	end

endmodule

### rtl/rioe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rioe_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module rioe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  rioe_pkg::job_t      push_job,
	output logic                pop_valid,
	input  logic                pop_ready,
	output rioe_pkg::job_t      pop_job
);
	import rioe_pkg::*;

	job_t                entries [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     fill_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (fill_q != (QPTR_W + 1)'(QDEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_job    = entries[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_job;
		end
	end

endmodule

### rtl/rioe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rioe_back
// Executes jobs: register map search and update, byte building and emission.
// ----------------------------------------------------------------------------
module rioe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  rioe_pkg::job_t      job,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_code_byte,
	output logic                out_last,
	output logic [1:0]          out_status
);
	import rioe_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_MAP   = 5'b00100,
		S_BUILD = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t              state_q;
	job_t                job_q;
	logic [MAP_CW-1:0]   count_q;
	logic [7:0]          last_byte_q;
	logic [MAP_CW-1:0]   scan_q;
	logic                rd_vld_s1;
	logic [PHYS_W-1:0]   idx_s1;
	logic [31:0]         rdata_s1;
	logic [2:0]          found_q;
	logic [PHYS_W-1:0]   phys_q [3];
	logic [1:0]          step_q;
	logic [7:0]          buf_q [MAX_BYTES];
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    emit_idx_q;
	logic [1:0]          status_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;
	logic [1:0]          out_status_q;

	logic [31:0]         table_mem [MAP_DEPTH];

	logic [31:0]         vregs [3];
	logic [31:0]         cur_vreg;
	logic                hit;
	logic [PHYS_W-1:0]   hit_phys;
	logic [1:0]          last_step;
	logic                map_full;
	logic                mem_we;
	logic                out_free;

	function automatic logic [7:0] rex_rr(input logic [PHYS_W-1:0] r,
			input logic [PHYS_W-1:0] b);
		return BYTE_REX_W | {5'b00000, r[3], 1'b0, b[3]};
	endfunction

	function automatic logic [7:0] modrm_rr(input logic [PHYS_W-1:0] reg_f,
			input logic [PHYS_W-1:0] rm_f);
		return {2'b11, reg_f[2:0], rm_f[2:0]};
	endfunction

	assign vregs[0]  = job_q.dest_vreg;
	assign vregs[1]  = job_q.src1_vreg;
	assign vregs[2]  = job_q.src2_vreg;
	assign cur_vreg  = vregs[step_q];
	assign last_step = (job_q.kind == JOB_LOAD) ? 2'd0 : 2'd2;
	assign map_full  = (count_q == MAP_CW'(MAP_DEPTH));
	assign mem_we    = (state_q == S_MAP) && !hit && !map_full;
	assign out_free  = !out_valid_q || out_ready;
	assign job_ready = (state_q == S_IDLE);

	// A register not found by the search may still have been added earlier
	// within this same item.
	always_comb begin
		case (step_q)
			2'd0: begin
				hit      = found_q[0];
				hit_phys = phys_q[0];
			end
			2'd1: begin
				hit      = found_q[1] || (vregs[1] == vregs[0]);
				hit_phys = found_q[1] ? phys_q[1] : phys_q[0];
			end
			2'd2: begin
				hit      = found_q[2] || (vregs[2] == vregs[0]) || (vregs[2] == vregs[1]);
				hit_phys = found_q[2] ? phys_q[2] :
					((vregs[2] == vregs[0]) ? phys_q[0] : phys_q[1]);
			end
			default: begin
				hit      = 1'b1;
				hit_phys = phys_q[0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[count_q[MAP_AW-1:0]] <= cur_vreg;
		end
		rdata_s1 <= table_mem[scan_q[MAP_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			job_q        <= '0;
			count_q      <= '0;
			last_byte_q  <= '0;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			found_q      <= '0;
			phys_q       <= '{default: '0};
			step_q       <= '0;
			buf_q        <= '{default: '0};
			len_q        <= '0;
			emit_idx_q   <= '0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= ST_OK;
		end else begin
			// The output slot takes a new byte whenever it is free and a byte
			// is being emitted; otherwise a taken byte leaves it empty.
			if (out_free) begin
				out_valid_q <= (state_q == S_EMIT);
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q      <= job;
						status_q   <= ST_OK;
						emit_idx_q <= '0;
						case (job.kind)
							JOB_PRO: begin
								count_q  <= '0;
								buf_q[0] <= BYTE_PUSH_RBP;
								buf_q[1] <= BYTE_REX_W;
								buf_q[2] <= BYTE_MOV_RM;
								buf_q[3] <= BYTE_RSP_RBP;
								len_q    <= LEN_W'(4);
								state_q  <= S_EMIT;
							end
							JOB_EPI: begin
								// Nothing to send right after a return byte.
								if (last_byte_q != BYTE_RET) begin
									buf_q[0] <= BYTE_POP_RBP;
									buf_q[1] <= BYTE_RET;
									len_q    <= LEN_W'(2);
									state_q  <= S_EMIT;
								end
							end
							JOB_RET: begin
								buf_q[0] <= BYTE_RET;
								len_q    <= LEN_W'(1);
								state_q  <= S_EMIT;
							end
							JOB_ALU, JOB_LOAD: begin
								scan_q  <= '0;
								found_q <= '0;
								step_q  <= '0;
								state_q <= S_SCAN;
							end
							default: begin
								buf_q[0] <= '0;
								status_q <= job.status;
								len_q    <= LEN_W'(1);
								state_q  <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_q != count_q) begin
						rd_vld_s1 <= 1'b1;
						idx_s1    <= PHYS_W'(scan_q);
						scan_q    <= scan_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (rd_vld_s1) begin
						for (int k = 0; k < 3; k++) begin
							if (!found_q[k] && rdata_s1 == vregs[k]) begin
								found_q[k] <= 1'b1;
								phys_q[k]  <= idx_s1;
							end
						end
					end
					if (scan_q == count_q && !rd_vld_s1) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					if (!hit && map_full) begin
						buf_q[0] <= '0;
						status_q <= ST_FULL;
						len_q    <= LEN_W'(1);
						state_q  <= S_EMIT;
					end else begin
						if (hit) begin
							phys_q[step_q] <= hit_phys;
						end else begin
							phys_q[step_q] <= PHYS_W'(count_q);
							count_q        <= count_q + 1'b1;
						end
						if (step_q == last_step) begin
							state_q <= S_BUILD;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				S_BUILD: begin
					if (job_q.kind == JOB_LOAD) begin
						buf_q[0] <= rex_rr('0, phys_q[0]);
						buf_q[1] <= BYTE_MOV_IMM;
						buf_q[2] <= modrm_rr('0, phys_q[0]);
						buf_q[3] <= job_q.imm_value[7:0];
						buf_q[4] <= job_q.imm_value[15:8];
						buf_q[5] <= job_q.imm_value[23:16];
						buf_q[6] <= job_q.imm_value[31:24];
						len_q    <= LEN_W'(7);
					end else if (phys_q[0] != phys_q[1]) begin
						buf_q[0] <= rex_rr(phys_q[1], phys_q[0]);
						buf_q[1] <= BYTE_MOV_RM;
						buf_q[2] <= modrm_rr(phys_q[1], phys_q[0]);
						buf_q[3] <= rex_rr(phys_q[2], phys_q[0]);
						buf_q[4] <= job_q.is_sub ? BYTE_SUB : BYTE_ADD;
						buf_q[5] <= modrm_rr(phys_q[2], phys_q[0]);
						len_q    <= LEN_W'(6);
					end else begin
						buf_q[0] <= rex_rr(phys_q[2], phys_q[0]);
						buf_q[1] <= job_q.is_sub ? BYTE_SUB : BYTE_ADD;
						buf_q[2] <= modrm_rr(phys_q[2], phys_q[0]);
						len_q    <= LEN_W'(3);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_byte_q   <= buf_q[emit_idx_q];
						out_last_q   <= (emit_idx_q == len_q - 1'b1);
						out_status_q <= status_q;
						// Error results do not count as emitted code.
						if (status_q == ST_OK) begin
							last_byte_q <= buf_q[emit_idx_q];
						end
						emit_idx_q <= emit_idx_q + 1'b1;
						if (emit_idx_q == len_q - 1'b1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_code_byte = out_byte_q;
	assign out_last      = out_last_q;
	assign out_status    = out_status_q;

endmodule
